// ===== sv/cscan_pkg.sv =====
// cscan_pkg: shared types and constants of the C-SCAN disk scheduler.
// Holds result kinds, register indexes, cell operations and the sequencer states.
// No dependencies.
package cscan_pkg;

  // Result kinds on out_result_kind
  localparam logic [1:0] KIND_SERVICE = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;
  localparam logic [1:0] KIND_FULL    = 2'd3;

  // Register index, taken from paddr[2]
  localparam logic REG_HEAD  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  // Register reset values
  localparam logic [15:0] HEAD_RESET  = 16'd0;
  localparam logic [16:0] COUNT_RESET = 17'h10000;

  // Operation applied to every cell of the sorted chain
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_ROTATE = 2'd2
  } cell_op_t;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXTEND = 5'b00010,
    ST_ROTATE = 5'b00100,
    ST_EMIT   = 5'b01000,
    ST_DIVIDE = 5'b10000
  } seq_state_t;

endpackage

// ===== sv/cscan_disk_scheduler.sv =====
// cscan_disk_scheduler: top level of the C-SCAN disk scheduler.
// Instantiates the sorted cell chain (cscan_cell) and the divider (cscan_div).
// Depends on cscan_pkg.
//
// Usage:
//   Requests enter on start/busy with in_request_cylinder and in_last_request.
//   A plain request leaves busy low, so one request per
//   cycle loads into a chain of MAX_REQUESTS+3 cells kept in descending order.
//   A refused request (beyond the cylinder count, or store full) gives one
//   result beat in the cycle after acceptance.
//   A request marked last raises busy and runs the schedule: it inserts the top
//   cylinder, the head and cylinder 0, then rotates the chain past the m
//   entries above the head, then gives one service beat per cycle for the
//   n = count+3 entries, then divides (one quotient bit a cycle) and takes
//   the quotient; the summary beat appears in the same cycle busy falls.
//   Results appear on out_* for exactly one cycle, marked by out_valid; the
//   receiver cannot stall. out_run_last marks the last beat an input caused.
//   Registers sit on an APB port: head_position at 0x0, cylinder_count at 0x4.
//   Synchronous reset empties the store, sets head 0 and count 65536.
module cscan_disk_scheduler #(
  parameter int MAX_REQUESTS  = 32,
  parameter int CYLINDER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_request_cylinder,
  input  logic        in_last_request,
  // result channel
  output logic        out_valid,
  output logic [1:0]  out_result_kind,
  output logic [15:0] out_service_cylinder,
  output logic [21:0] out_seek_total,
  output logic [21:0] out_seek_average,
  output logic        out_run_last,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cscan_pkg::*;

  localparam int CW    = (CYLINDER_BITS < 17) ? CYLINDER_BITS : 17;
  localparam int DEPTH = MAX_REQUESTS + 3;
  localparam int NW    = $clog2(DEPTH + 1);
  localparam int RW    = $clog2(MAX_REQUESTS + 1);
  localparam int TW    = CW + 2;
  localparam logic [31:0] LIM = 32'd1 << CYLINDER_BITS;

  // Configuration registers
  logic [15:0] head_r;
  logic [16:0] cnt_r;

  // Sequencer and datapath registers
  seq_state_t    state_r, state_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic [1:0]    ext_r,   ext_nxt;
  logic [NW-1:0] idx_r,   idx_nxt;
  logic [RW-1:0] reqn_r,  reqn_nxt;
  logic [CW-1:0] pos_r,   pos_nxt;
  logic [TW-1:0] total_r, total_nxt;

  logic          ovalid_r, ovalid_nxt;
  logic [1:0]    okind_r,  okind_nxt;
  logic [15:0]   ocyl_r,   ocyl_nxt;
  logic [21:0]   otot_r,   otot_nxt;
  logic [21:0]   oavg_r,   oavg_nxt;
  logic          olast_r,  olast_nxt;

  // Derived values
  logic [CW:0]   cnt_eff;
  logic [CW-1:0] top_w;
  logic [CW-1:0] head_eff;
  logic          accept;
  logic          req_oor;
  logic          store_full;
  logic          cfg_wr;

  // Chain signals
  cell_op_t      op;
  logic [CW-1:0] ins_val;
  logic [CW-1:0] val_w   [DEPTH];
  logic          moves_w [DEPTH];
  logic [CW-1:0] cyl0;
  logic [CW-1:0] diff;

  // Divider signals
  logic          div_start;
  logic          div_done;
  logic [TW-1:0] div_quo;

  // APB register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_HEAD) ? {16'd0, head_r} : {15'd0, cnt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= HEAD_RESET;
      cnt_r  <= COUNT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_HEAD:  head_r <= pwdata[15:0];
        REG_COUNT: cnt_r  <= pwdata[16:0];
        default:   head_r <= head_r;
      endcase
    end
  end

  // Clamp the cylinder count and the head position
  always_comb begin
    if (cnt_r == '0) begin
      cnt_eff = (CW + 1)'(1);
    end else if ({15'd0, cnt_r} > LIM) begin
      cnt_eff = (CW + 1)'(LIM);
    end else begin
      cnt_eff = (CW + 1)'(cnt_r);
    end
  end

  assign top_w    = CW'(cnt_eff - (CW + 1)'(1));
  assign head_eff = ({16'd0, head_r} > 32'(top_w)) ? top_w : CW'(head_r);

  // Input beat checks
  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign req_oor    = 32'(in_request_cylinder) >= 32'(cnt_eff);
  assign store_full = count_r >= NW'(MAX_REQUESTS);

  // Row of cells, slot 0 holds the largest value
  assign cyl0 = val_w[0];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    cscan_cell #(
      .CW  (CW),
      .NW  (NW),
      .IDX (g)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .count      (count_r),
      .ins_val    (ins_val),
      .left_val   ((g == 0) ? ins_val : val_w[(g == 0) ? 0 : g - 1]),
      .left_moves ((g == 0) ? 1'b0 : moves_w[(g == 0) ? 0 : g - 1]),
      .right_val  ((g == DEPTH - 1) ? cyl0 : val_w[(g == DEPTH - 1) ? g : g + 1]),
      .wrap_val   (cyl0),
      .val        (val_w[g]),
      .moves      (moves_w[g])
    );
  end

  // Seek distance to the next served cylinder
  assign diff = (cyl0 > pos_r) ? (cyl0 - pos_r) : (pos_r - cyl0);

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ext_nxt    = ext_r;
    idx_nxt    = idx_r;
    reqn_nxt   = reqn_r;
    pos_nxt    = pos_r;
    total_nxt  = total_r;
    op         = CELL_HOLD;
    ins_val    = CW'(in_request_cylinder);
    div_start  = 1'b0;
    ovalid_nxt = 1'b0;
    okind_nxt  = KIND_SERVICE;
    ocyl_nxt   = '0;
    otot_nxt   = '0;
    oavg_nxt   = '0;
    olast_nxt  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // refuse, or load the request into the chain
          if (req_oor || store_full) begin
            ovalid_nxt = 1'b1;
            okind_nxt  = req_oor ? KIND_REJECT : KIND_FULL;
            olast_nxt  = !in_last_request;
            reqn_nxt   = RW'(count_r);
          end else begin
            op        = CELL_INSERT;
            count_nxt = count_r + 1'b1;
            reqn_nxt  = RW'(count_r + 1'b1);
          end
          if (in_last_request) begin
            state_nxt = ST_EXTEND;
            ext_nxt   = '0;
          end
        end
      end

      ST_EXTEND: begin
        // add the top cylinder, the head and cylinder 0
        op        = CELL_INSERT;
        count_nxt = count_r + 1'b1;
        case (ext_r)
          2'd0:    ins_val = top_w;
          2'd1:    ins_val = head_eff;
          default: ins_val = '0;
        endcase
        ext_nxt = ext_r + 1'b1;
        if (ext_r == 2'd2) begin
          state_nxt = ST_ROTATE;
          pos_nxt   = head_eff;
          total_nxt = '0;
          idx_nxt   = '0;
        end
      end

      ST_ROTATE: begin
        // move entries above the head behind the rest
        if (cyl0 > head_eff) begin
          op = CELL_ROTATE;
        end else begin
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        // serve slot 0 and rotate
        op         = CELL_ROTATE;
        ovalid_nxt = 1'b1;
        okind_nxt  = KIND_SERVICE;
        ocyl_nxt   = 16'(cyl0);
        total_nxt  = total_r + TW'(diff);
        pos_nxt    = cyl0;
        idx_nxt    = idx_r + 1'b1;
        if (idx_r == NW'(count_r - 1'b1)) begin
          state_nxt = ST_DIVIDE;
          count_nxt = '0;
          div_start = 1'b1;
        end
      end

      ST_DIVIDE: begin
        // emit the summary once the average is ready
        if (div_done) begin
          ovalid_nxt = 1'b1;
          okind_nxt  = KIND_SUMMARY;
          otot_nxt   = 22'(total_r);
          oavg_nxt   = (reqn_r == '0) ? 22'd0 : 22'(div_quo);
          olast_nxt  = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      ext_r    <= '0;
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ext_r    <= ext_nxt;
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    reqn_r  <= reqn_nxt;
    pos_r   <= pos_nxt;
    total_r <= total_nxt;
    okind_r <= okind_nxt;
    ocyl_r  <= ocyl_nxt;
    otot_r  <= otot_nxt;
    oavg_r  <= oavg_nxt;
    olast_r <= olast_nxt;
  end

  // Average seek per request
  cscan_div #(
    .TW (TW),
    .RW (RW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (total_nxt),
    .divisor  (reqn_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Result beat
  assign out_valid            = ovalid_r;
  assign out_result_kind      = okind_r;
  assign out_service_cylinder = ocyl_r;
  assign out_seek_total       = otot_r;
  assign out_seek_average     = oavg_r;
  assign out_run_last         = olast_r;

endmodule

// ===== sv/cscan_cell.sv =====
// cscan_cell: one slot of the descending sorted chain.
// Inserts by comparing against the broadcast value, rotates towards slot 0.
// Depends on cscan_pkg.
module cscan_cell #(
  parameter int CW  = 16,
  parameter int NW  = 6,
  parameter int IDX = 0
) (
  input  logic               clk,
  input  cscan_pkg::cell_op_t op,
  input  logic [NW-1:0]      count,
  input  logic [CW-1:0]      ins_val,
  input  logic [CW-1:0]      left_val,
  input  logic               left_moves,
  input  logic [CW-1:0]      right_val,
  input  logic [CW-1:0]      wrap_val,
  output logic [CW-1:0]      val,
  output logic               moves
);
  import cscan_pkg::*;

  logic [CW-1:0] val_r;
  logic [CW-1:0] val_nxt;
  logic          occupied;
  logic          tail;

  assign occupied = count > NW'(IDX);
  assign tail     = count == NW'(IDX + 1);

  // Slot gives way when empty or holding a smaller value
  assign moves = !occupied || (val_r < ins_val);
  assign val   = val_r;

  // Pick the next entry for this slot
  always_comb begin
    val_nxt = val_r;
    unique case (op)
      CELL_HOLD: val_nxt = val_r;
      CELL_INSERT: begin
        if (moves) val_nxt = left_moves ? left_val : ins_val;
      end
      CELL_ROTATE: val_nxt = tail ? wrap_val : right_val;
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== sv/cscan_div.sv =====
// cscan_div: restoring divider, one quotient bit per cycle.
// Produces the average seek from the total and the request count.
// Depends on cscan_pkg (style only, no shared items needed beyond import).
module cscan_div #(
  parameter int TW = 18,
  parameter int RW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [TW-1:0] dividend,
  input  logic [RW-1:0] divisor,
  output logic          done,
  output logic [TW-1:0] quotient
);
  import cscan_pkg::*;

  localparam int SW = $clog2(TW + 1);

  logic [RW-1:0] rem_r,  rem_nxt;
  logic [TW-1:0] quo_r,  quo_nxt;
  logic [RW-1:0] div_r;
  logic [SW-1:0] step_r, step_nxt;
  logic          run_r,  run_nxt;
  logic          done_r, done_nxt;
  logic [RW:0]   trial;
  logic          fits;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_r, quo_r[TW-1]};
  assign fits  = trial >= {1'b0, div_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      step_nxt = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      rem_nxt  = fits ? RW'(trial - {1'b0, div_r}) : RW'(trial);
      quo_nxt  = {quo_r[TW-2:0], fits};
      step_nxt = step_r + 1'b1;
      if (step_r == SW'(TW - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) div_r <= divisor;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for cscan_disk_scheduler: directed and random request
// batches, each predicted in place and checked beat by beat against the results.
// Depends on cscan_pkg and the cscan_disk_scheduler RTL.
module testbench;
  import cscan_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REQ        = 32;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 25;
  localparam int SHOWN_ERRORS   = 10;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] cyl;
    logic [21:0] total;
    logic [21:0] avg;
    logic        run_last;
  } sched_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] in_request_cylinder = '0;
  logic        in_last_request = 1'b0;
  logic        out_valid;
  logic [1:0]  out_result_kind;
  logic [15:0] out_service_cylinder;
  logic [21:0] out_seek_total;
  logic [21:0] out_seek_average;
  logic        out_run_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the scheduler: stored requests and both registers
  logic [15:0] stored_cyls[$];
  logic [15:0] head_reg = HEAD_RESET;
  logic [16:0] count_reg = COUNT_RESET;

  sched_beat_t beats_due[$];

  int mismatches = 0;
  int items_sent = 0;
  int schedules_seen = 0;
  int refusals_seen = 0;
  int reg_writes = 0;
  int stall_cycles = 0;

  cscan_disk_scheduler DUT (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_request_cylinder(in_request_cylinder), .in_last_request(in_last_request),
    .out_valid(out_valid), .out_result_kind(out_result_kind),
    .out_service_cylinder(out_service_cylinder), .out_seek_total(out_seek_total),
    .out_seek_average(out_seek_average), .out_run_last(out_run_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Effective cylinder count: zero acts as one, clamp at the 16-bit disk size
  function automatic int unsigned eff_count();
    int unsigned cnt;
    cnt = 32'(count_reg);
    if (cnt > 65536) cnt = 65536;
    if (cnt == 0) cnt = 1;
    return cnt;
  endfunction

  function automatic int unsigned eff_head();
    int unsigned top;
    top = eff_count() - 1;
    return (32'(head_reg) > top) ? top : 32'(head_reg);
  endfunction

  task automatic push_beat(input logic [1:0] kind, input int unsigned cyl,
                           input int unsigned total, input int unsigned avg);
    sched_beat_t b;
    b.kind = kind;
    b.cyl = cyl[15:0];
    b.total = total[21:0];
    b.avg = avg[21:0];
    b.run_last = 1'b0;
    beats_due.push_back(b);
  endtask

  // Work out the beats that one accepted request causes
  task automatic predict_request(input logic [15:0] cyl, input logic last_req);
    int unsigned cnt, top, head, split, pos, total, c, i, first_new;
    int unsigned ext[$];
    int unsigned visit[$];
    first_new = beats_due.size();
    cnt = eff_count();
    if (cyl >= cnt) push_beat(KIND_REJECT, 0, 0, 0);
    else if (stored_cyls.size() >= MAX_REQ) push_beat(KIND_FULL, 0, 0, 0);
    else stored_cyls.push_back(cyl);

    if (last_req) begin
      top = cnt - 1;
      head = eff_head();
      foreach (stored_cyls[k]) ext.push_back(32'(stored_cyls[k]));
      ext.push_back(0);
      ext.push_back(head);
      ext.push_back(top);
      ext.sort();
      split = 0;
      while (split < ext.size() && ext[split] <= head) split++;
      // sweep down from the head to 0, then wrap to the top and sweep down again
      for (i = split; i > 0; i--) visit.push_back(ext[i - 1]);
      for (i = ext.size(); i > split; i--) visit.push_back(ext[i - 1]);
      pos = head;
      total = 0;
      foreach (visit[k]) begin
        c = visit[k];
        total += (c > pos) ? c - pos : pos - c;
        pos = c;
        push_beat(KIND_SERVICE, c, 0, 0);
      end
      push_beat(KIND_SUMMARY, 0, total,
                stored_cyls.size() ? total / stored_cyls.size() : 0);
      stored_cyls.delete();
    end
    if (beats_due.size() > first_new) beats_due[beats_due.size() - 1].run_last = 1'b1;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    if (mismatches <= SHOWN_ERRORS)
      $display("MISMATCH %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) report_mismatch(what, want, got);
  endtask

  // Check each result beat against the oldest one due
  always @(posedge clk) begin
    sched_beat_t want;
    if (rst_n && out_valid) begin
      if (beats_due.size() == 0) begin
        report_mismatch("beat with nothing due, kind", 'x, 32'(out_result_kind));
      end else begin
        want = beats_due.pop_front();
        check_field("result_kind", 32'(want.kind), 32'(out_result_kind));
        check_field("service_cylinder", 32'(want.cyl), 32'(out_service_cylinder));
        check_field("seek_total", 32'(want.total), 32'(out_seek_total));
        check_field("seek_average", 32'(want.avg), 32'(out_seek_average));
        check_field("run_last", 32'(want.run_last), 32'(out_run_last));
        if (want.kind == KIND_SUMMARY) schedules_seen++;
        if (want.kind == KIND_REJECT || want.kind == KIND_FULL) refusals_seen++;
      end
    end
  end

  // Abort when nothing moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no activity for %0d cycles, %0d beats still due",
               stall_cycles, beats_due.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one request and hold it until the block takes it; start stays high
  task automatic send_request(input logic [15:0] cyl, input logic last_req);
    start <= 1'b1;
    in_request_cylinder <= cyl;
    in_last_request <= last_req;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    predict_request(cyl, last_req);
  endtask

  // Drop start for a random number of cycles
  task automatic idle_gap(input int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Drop start and wait for every due beat and the block to go quiet
  task automatic settle_block();
    start <= 1'b0;
    while (beats_due.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup, access, then drop psel and penable before the next transfer
  task automatic apb_transfer(input logic wr, input logic reg_sel,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {reg_sel, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read_check(input logic reg_sel, input logic [31:0] want);
    logic [31:0] got;
    apb_transfer(1'b0, reg_sel, '0, got);
    check_field(reg_sel == REG_HEAD ? "head_position read" : "cylinder_count read",
                want, got);
  endtask

  // Write both registers while idle, then read them back
  task automatic cfg_apply(input logic [31:0] head, input logic [31:0] count);
    logic [31:0] unused;
    settle_block();
    apb_transfer(1'b1, REG_HEAD, head, unused);
    head_reg = head[15:0];
    apb_transfer(1'b1, REG_COUNT, count, unused);
    count_reg = count[16:0];
    reg_writes += 2;
    cfg_read_check(REG_HEAD, {16'd0, head_reg});
    cfg_read_check(REG_COUNT, {15'd0, count_reg});
  endtask

  // Random cylinder: mostly valid, some at the edges, some beyond the disk
  function automatic logic [15:0] pick_cylinder(input int noise_pct);
    int unsigned cnt, r;
    cnt = eff_count();
    r = $urandom_range(99);
    if (cnt < 65536 && r < noise_pct) return 16'($urandom_range(65535, cnt));
    if (r < noise_pct + 4) return 16'(eff_head());
    if (r < noise_pct + 7) return 16'(cnt - 1);
    if (r < noise_pct + 10) return 16'd0;
    return 16'($urandom_range(cnt - 1, 0));
  endfunction

  task automatic run_batch(input int len, input int noise_pct, input int idle_pct,
                           input logic close_batch);
    int i;
    for (i = 0; i < len; i++) begin
      send_request(pick_cylinder(noise_pct), close_batch && (i == len - 1));
      idle_gap(idle_pct);
    end
  endtask

  task automatic test_reset_defaults();
    cfg_read_check(REG_HEAD, {16'd0, HEAD_RESET});
    cfg_read_check(REG_COUNT, {15'd0, COUNT_RESET});
    send_request(16'd0, 1'b0);
    send_request(16'hFFFF, 1'b0);
    send_request(16'd100, 1'b0);
    send_request(16'd40000, 1'b1);
  endtask

  // Refused request marked last on an empty store
  task automatic test_empty_batch();
    cfg_apply(32'd300, 32'd1000);
    send_request(16'd1000, 1'b1);
  endtask

  // Head beyond the disk clamps to the top: one downward sweep
  task automatic test_head_at_top();
    cfg_apply(32'd5000, 32'd1000);
    send_request(16'd999, 1'b0);
    send_request(16'd3, 1'b0);
    send_request(16'd500, 1'b1);
  endtask

  // Requests on the head cylinder go in the first sweep
  task automatic test_requests_at_head();
    cfg_apply(32'd500, 32'd1000);
    send_request(16'd500, 1'b0);
    send_request(16'd500, 1'b0);
    send_request(16'd501, 1'b0);
    send_request(16'd499, 1'b1);
  endtask

  // Count of zero acts as one; refused last still runs the schedule
  task automatic test_count_zero();
    cfg_apply(32'd7, 32'd0);
    send_request(16'd0, 1'b0);
    send_request(16'd1, 1'b1);
  endtask

  // Count beyond the disk clamps to 65536
  task automatic test_count_over();
    cfg_apply(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(16'hFFFF, 1'b0);
    send_request(16'd0, 1'b1);
  endtask

  // Overfill the store so the trailing requests are dropped
  task automatic test_store_overflow();
    cfg_apply($urandom_range(65535), 32'h10000);
    run_batch($urandom_range(38, 33), 0, 0, 1'b1);
  endtask

  task automatic test_random_traffic(input int phase, input int idle_pct);
    int phase_end, len;
    case (phase)
      0: cfg_apply($urandom_range(65535), $urandom_range(1) ? 32'h10000 : 32'h1FFFF);
      1: cfg_apply($urandom_range(80), $urandom_range(64, 2));
      2: cfg_apply(32'hFFFF, $urandom_range(65536, 1));
      default: cfg_apply($urandom, $urandom);
    endcase
    phase_end = items_sent + PHASE_ITEMS;
    while (items_sent < phase_end) begin
      len = ($urandom_range(99) < 15) ? $urandom_range(34, 16) : $urandom_range(12, 1);
      // mostly closed batches; a few leave the store open for the next one
      run_batch(len, 10, idle_pct, $urandom_range(99) >= 10);
      if ($urandom_range(99) < 20)
        cfg_apply($urandom, $urandom_range(99) < 50 ? $urandom_range(200, 1) : $urandom);
      else if ($urandom_range(99) < 15)
        settle_block();
    end
    // close any open batch before the next phase
    send_request(pick_cylinder(0), 1'b1);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_empty_batch();
    test_head_at_top();
    test_requests_at_head();
    test_count_zero();
    test_count_over();
    test_store_overflow();
    // receiver cannot stall, so only the sender idles
    test_random_traffic(0, 0);
    test_random_traffic(1, 70);
    test_random_traffic(2, 0);
    test_random_traffic(3, 32);

    start <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d requests, %0d schedules, %0d refusals, %0d register writes",
             items_sent, schedules_seen, refusals_seen, reg_writes);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0 && beats_due.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
